/* src/lbs_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants of the LED bar stack animation engine.
// No dependencies.
package lbs_pkg;

  typedef enum logic [2:0] {
    KIND_TICK = 3'd0,
    KIND_UP   = 3'd1,
    KIND_DOWN = 3'd2,
    KIND_LOW  = 3'd3,
    KIND_OFF  = 3'd4
  } kind_t;

  localparam logic [2:0] REG_FIRST   = 3'd0;
  localparam logic [2:0] REG_LAST    = 3'd1;
  localparam logic [2:0] REG_REVERSE = 3'd2;
  localparam logic [2:0] REG_NIMH    = 3'd3;
  localparam logic [2:0] REG_FILL    = 3'd4;

  localparam logic [7:0] BAR_BLUE = 8'd175;

  // One job for the back end: a run of pixel writes or one single result.
  typedef enum logic [1:0] {
    JOB_FILL  = 2'd0,   // all pixels, black or lit
    JOB_STACK = 2'd1,   // all pixels, lit below level or at position
    JOB_ONE   = 2'd2,   // one pixel write
    JOB_NONE  = 2'd3    // one empty result
  } job_kind_t;

  typedef struct packed {
    job_kind_t  kind;
    logic       lit;
    logic [8:0] level;   // signed compare values
    logic [8:0] pos;
    logic [7:0] index;   // logical index for JOB_ONE
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic       done;
  } job_t;

endpackage

/* src/led_bar_stack_animation_engine.sv */
`timescale 1ns / 1ps
// LED bar stack animation engine top level: config registers, front, queue, back.
// Depends on lbs_pkg, lbs_front, lbs_queue, lbs_back.
//
// Each input beat is a tick or a mode start; it yields zero, one or NUM_LEDS
// result beats, pixel writes or one empty result. The front end takes a beat
// per cycle whenever the job queue has room; the step interval of a stack
// start comes from a reciprocal multiply in the same cycle. The first result
// beat of an item passes the front job register, the queue and the back-end
// output registers; the back end then sends one result beat per cycle unless
// the output stalls, so a full-bar item gives NUM_LEDS result beats. A two-job
// queue lets the front classify the next beat as the back end streams pixels.
module led_bar_stack_animation_engine import lbs_pkg::*; #(
  parameter int NUM_LEDS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_kind,
  input  logic [31:0] in_now_ms,
  input  logic [6:0]  in_battery_level,
  input  logic [15:0] in_duration_ms,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_pixel_valid,
  output logic [7:0]  out_pixel_index,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  output logic        out_sequence_done,
  output logic        out_last
);
  logic [7:0]  first_r, last_r;
  logic        rev_r, nimh_r;
  logic [15:0] fill_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_r <= 8'd0; last_r <= 8'd15; rev_r <= 1'b0; nimh_r <= 1'b0; fill_r <= 16'd30;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FIRST:   first_r <= cfg_data[7:0];
        REG_LAST:    last_r  <= cfg_data[7:0];
        REG_REVERSE: rev_r   <= cfg_data[0];
        REG_NIMH:    nimh_r  <= cfg_data[0];
        REG_FILL:    fill_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  logic fj_valid, q_full, q_valid, q_take;
  job_t fj, qj;

  lbs_front #(.NUM_LEDS(NUM_LEDS)) u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_kind, .in_now_ms, .in_battery_level,
    .in_duration_ms, .nimh(nimh_r), .fill_interval(fill_r),
    .job_valid(fj_valid), .job(fj), .job_full(q_full)
  );

  lbs_queue u_queue (
    .clk, .rst_n, .wr_en(fj_valid), .wr_job(fj), .full(q_full),
    .rd_valid(q_valid), .rd_job(qj), .rd_en(q_take)
  );

  lbs_back #(.NUM_LEDS(NUM_LEDS)) u_back (
    .clk, .rst_n, .job_valid(q_valid), .job(qj), .job_take(q_take),
    .first_pixel(first_r), .last_pixel(last_r), .reverse_order(rev_r),
    .out_valid, .out_stall, .out_pixel_valid, .out_pixel_index, .out_red,
    .out_green, .out_blue, .out_sequence_done, .out_last
  );
endmodule

/* src/lbs_front.sv */
`timescale 1ns / 1ps
// Front end: holds mode state, classifies each input beat into a pixel job.
// Depends on lbs_pkg.
module lbs_front import lbs_pkg::*; #(
  parameter int NUM_LEDS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_kind,
  input  logic [31:0] in_now_ms,
  input  logic [6:0]  in_battery_level,
  input  logic [15:0] in_duration_ms,
  input  logic        nimh,
  input  logic [15:0] fill_interval,
  output logic        job_valid,
  output job_t        job,
  input  logic        job_full
);
  localparam int TOTAL = 1 + ((NUM_LEDS + 1) * (NUM_LEDS + 2)) / 2;
  // reciprocal of TOTAL, exact for every 16-bit duration
  localparam int RSH   = 16 + $clog2(TOTAL);
  localparam int RECIP = ((1 << RSH) + TOTAL - 1) / TOTAL;
  localparam logic [17:0] RECIP18 = 18'(RECIP);
  localparam logic [7:0] N8 = 8'(NUM_LEDS);

  typedef enum logic [2:0] {
    M_IDLE = 3'd0, M_UP = 3'd1, M_DOWN = 3'd2, M_LOW = 3'd3, M_OFF = 3'd4, M_FILL = 3'd5
  } mode_t;

  mode_t       mode_r;
  logic [7:0]  fpos_r, pile_r;
  logic [31:0] prev_r;
  logic [15:0] step_r, blink_r;
  logic        pulse_r;
  logic [7:0]  cr_r, cg_r, cb_r;

  logic        job_valid_r;
  job_t        job_r;

  logic [31:0] elapsed;
  logic        accept;
  logic [33:0] seq_prod;
  logic [15:0] seq_q;
  assign accept   = in_valid && !in_stall;
  assign in_stall = job_full;
  assign elapsed  = in_now_ms - prev_r;
  assign job_valid = job_valid_r;
  assign job       = job_r;

  // seq interval: duration / TOTAL by reciprocal multiply
  assign seq_prod = {18'd0, in_duration_ms} * {16'd0, RECIP18};
  assign seq_q    = 16'(seq_prod >> RSH);

  // colour from battery level
  logic [7:0] lr, lg, lb;
  always_comb begin
    logic [6:0] o;
    logic [6:0] s;
    o = nimh ? 7'd15 : 7'd0;
    s = 7'd0;
    lr = 8'd0; lg = 8'd0; lb = 8'd0;
    if (in_battery_level >= 7'd15 + o) begin
      lb = BAR_BLUE;
    end else if (in_battery_level >= 7'd10 + o) begin
      s  = 7'd15 + o - in_battery_level;
      lr = (s >= 7'd4) ? 8'd140 : 8'(s * 7'd42);
      lg = 8'(s * 7'd7);
      case (s[2:0])
        3'd1:    lb = 8'd122;
        3'd2:    lb = 8'd70;
        3'd3:    lb = 8'd17;
        default: lb = 8'd0;
      endcase
    end else if (in_battery_level >= 7'd5 + o) begin
      s  = 7'd10 + o - in_battery_level;
      lr = 8'd140 + 8'(s * 7'd7);
      lg = 8'd35 - 8'(s * 7'd7);
    end else begin
      lr = 8'd255;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_IDLE; fpos_r <= '0; pile_r <= '0; prev_r <= '0;
      step_r <= 16'd30; blink_r <= 16'd5000; pulse_r <= 1'b0;
      cr_r <= '0; cg_r <= '0; cb_r <= BAR_BLUE; job_valid_r <= 1'b0;
    end else begin
      if (!job_full) job_valid_r <= 1'b0;
      if (accept) begin
        job_r.done  <= 1'b0;
        job_r.lit   <= 1'b0;
        job_r.level <= '0; job_r.pos <= '0; job_r.index <= '0;
        job_r.r <= cr_r; job_r.g <= cg_r; job_r.b <= cb_r;
        case (in_kind)
          KIND_UP, KIND_DOWN: begin
            mode_r <= (in_kind == KIND_UP) ? M_UP : M_DOWN;
            fpos_r <= N8;
            pile_r <= (in_kind == KIND_UP) ? 8'd0 : N8;
            step_r <= (seq_q < 16'd5) ? 16'd5 : seq_q;
            cr_r <= lr; cg_r <= lg; cb_r <= lb;
            job_r.r <= lr; job_r.g <= lg; job_r.b <= lb;
            job_r.kind <= JOB_FILL; job_r.lit <= (in_kind == KIND_DOWN);
            job_valid_r <= 1'b1;
          end
          KIND_LOW, KIND_OFF: begin
            mode_r <= (in_kind == KIND_LOW) ? M_LOW : M_OFF;
            blink_r <= in_duration_ms; prev_r <= in_now_ms; pulse_r <= 1'b0;
            job_r.kind <= JOB_FILL;
            job_valid_r <= 1'b1;
          end
          KIND_TICK: begin
            case (mode_r)
              M_UP: begin
                if (pile_r > N8) begin
                  mode_r <= M_FILL; step_r <= fill_interval; pile_r <= '0;
                  cr_r <= lr; cg_r <= lg; cb_r <= lb;
                  job_r.kind <= JOB_FILL; job_r.done <= 1'b1; job_valid_r <= 1'b1;
                end else if (elapsed >= 32'(step_r)) begin
                  prev_r <= in_now_ms;
                  job_r.kind <= JOB_STACK; job_r.level <= {1'b0, pile_r};
                  job_r.pos <= {1'b0, fpos_r}; job_valid_r <= 1'b1;
                  if (fpos_r - 8'd1 == pile_r) begin
                    pile_r <= pile_r + 8'd1; fpos_r <= N8;
                  end else begin
                    fpos_r <= fpos_r - 8'd1;
                  end
                end
              end
              M_FILL: begin
                step_r <= fill_interval;
                if (pile_r >= N8) begin
                  cr_r <= lr; cg_r <= lg; cb_r <= lb; pile_r <= '0;
                  job_r.kind <= JOB_FILL; job_valid_r <= 1'b1;
                end else if (elapsed >= 32'(fill_interval)) begin
                  prev_r <= in_now_ms; pile_r <= pile_r + 8'd1;
                  job_r.kind <= JOB_ONE; job_r.lit <= 1'b1; job_r.index <= pile_r;
                  job_valid_r <= 1'b1;
                end
              end
              M_DOWN: begin
                if (pile_r[7]) begin
                  mode_r <= M_IDLE;
                  job_r.kind <= JOB_NONE; job_r.done <= 1'b1; job_valid_r <= 1'b1;
                end else if (elapsed >= 32'(step_r)) begin
                  prev_r <= in_now_ms;
                  job_r.kind <= JOB_STACK; job_r.level <= {pile_r[7], pile_r};
                  job_r.pos <= {fpos_r[7], fpos_r}; job_valid_r <= 1'b1;
                  if ($signed(fpos_r + 8'd1) > $signed(N8) && fpos_r != 8'd127) begin
                    pile_r <= pile_r - 8'd1; fpos_r <= pile_r - 8'd1;
                  end else begin
                    fpos_r <= fpos_r + 8'd1;
                  end
                end
              end
              M_LOW: begin
                logic p;
                p = pulse_r;
                if (elapsed >= 32'(blink_r)) begin
                  prev_r <= in_now_ms; p = ~pulse_r;
                end
                pulse_r <= p;
                job_r.kind <= JOB_ONE; job_r.lit <= 1'b1;
                job_r.r <= p ? 8'd125 : 8'd0; job_r.g <= '0; job_r.b <= '0;
                job_valid_r <= 1'b1;
              end
              M_OFF: begin
                logic p;
                logic [31:0] e;
                p = pulse_r; e = elapsed;
                if (elapsed >= 32'(blink_r)) begin
                  prev_r <= in_now_ms; p = 1'b0; e = '0;
                end
                if (e >= 32'(blink_r) - 32'd50) p = 1'b1;
                pulse_r <= p;
                job_r.kind <= JOB_ONE; job_r.lit <= 1'b1;
                job_r.r <= p ? 8'd250 : 8'd0; job_r.g <= '0; job_r.b <= '0;
                job_valid_r <= 1'b1;
              end
              default: ;
            endcase
          end
          default: ;
        endcase
      end
    end
  end
endmodule

/* src/lbs_queue.sv */
`timescale 1ns / 1ps
// Two-entry job queue between front and back end.
// Depends on lbs_pkg.
module lbs_queue import lbs_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic wr_en,
  input  job_t wr_job,
  output logic full,
  output logic rd_valid,
  output job_t rd_job,
  input  logic rd_en
);
  job_t       q_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full     = (cnt_r == 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_job   = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= '0;
    end else begin
      if (wr_en && !full) begin
        q_r[wp_r] <= wr_job; wp_r <= ~wp_r;
      end
      if (rd_en && rd_valid) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(wr_en && !full) - 2'(rd_en && rd_valid);
    end
  end
endmodule

/* src/lbs_back.sv */
`timescale 1ns / 1ps
// Back end: expands a job into pixel result beats, one per cycle unless the output stalls.
// Depends on lbs_pkg.
module lbs_back import lbs_pkg::*; #(
  parameter int NUM_LEDS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       job_valid,
  input  job_t       job,
  output logic       job_take,
  input  logic [7:0] first_pixel,
  input  logic [7:0] last_pixel,
  input  logic       reverse_order,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_pixel_valid,
  output logic [7:0] out_pixel_index,
  output logic [7:0] out_red,
  output logic [7:0] out_green,
  output logic [7:0] out_blue,
  output logic       out_sequence_done,
  output logic       out_last
);
  localparam int CW = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
  localparam logic [CW-1:0] LASTI = CW'(NUM_LEDS - 1);

  logic [CW-1:0] i_r;
  logic          ov_r;
  logic          load;
  logic          multi, fin, on;
  logic [7:0]    li;

  assign multi = (job.kind == JOB_FILL) || (job.kind == JOB_STACK);
  assign fin   = !multi || (i_r == LASTI);
  assign load  = job_valid && (!ov_r || !out_stall);
  assign job_take = load && fin;
  assign out_valid = ov_r;
  assign li = multi ? 8'(i_r) : job.index;

  always_comb begin
    case (job.kind)
      JOB_FILL:  on = job.lit;
      JOB_STACK: on = ($signed({1'b0, 8'(i_r)}) < $signed(job.level)) ||
                      ({1'b0, 8'(i_r)} == job.pos);
      JOB_ONE:   on = job.lit;
      default:   on = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0; i_r <= '0;
    end else begin
      if (ov_r && !out_stall) ov_r <= 1'b0;
      if (load) begin
        ov_r <= 1'b1;
        i_r  <= fin ? '0 : i_r + CW'(1);
        out_pixel_valid   <= (job.kind != JOB_NONE);
        out_pixel_index   <= (job.kind == JOB_NONE) ? 8'd0 :
                             (reverse_order ? last_pixel - li : first_pixel + li);
        out_red           <= on ? job.r : 8'd0;
        out_green         <= on ? job.g : 8'd0;
        out_blue          <= on ? job.b : 8'd0;
        out_sequence_done <= job.done;
        out_last          <= fin;
      end
    end
  end
endmodule
